/* rtl/hsla_pkg.sv */
package hsla_pkg;

    // one input item: hue in 1/16 degree, saturation and lightness in 1/16 percent
    typedef struct packed {
        logic signed [15:0] hue;
        logic signed [11:0] saturation;
        logic signed [11:0] lightness;
        logic        [9:0]  opacity;
    } t_hsla_in;

    // one result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } t_rgba_out;

    // per-channel numerators over CH_DEN, handed from the front end to the scalers
    typedef struct packed {
        logic [32:0] red;
        logic [32:0] green;
        logic [32:0] blue;
    } t_chan_num;

    // 60 degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    localparam int PIPE_DEPTH = 7;

    // hue handling: bias by six full turns so the wrapped value is non-negative
    localparam logic [17:0] HUE_BIAS    = 18'd34560;
    localparam logic [12:0] HUE_RECIP15 = 13'd4370;    // ceil(2^16 / 15)
    localparam logic [16:0] HUE_SECTOR  = 17'd960;
    localparam logic [11:0] SEC_RECIP6  = 12'd43;      // about 2^8 / 6
    localparam logic [6:0]  SEC_COUNT   = 7'd6;

    localparam logic [10:0] PCT_FULL    = 11'd1600;
    localparam logic [10:0] PCT_HALF    = 11'd800;

    // all channel terms are kept over CH_DEN = 1600 * 1600 * 960
    localparam logic [31:0] CD_SCALE    = 32'd960;
    localparam logic [31:0] CN_HALF     = 32'd480;
    localparam logic [31:0] MD_SCALE    = 32'd1536000;
    localparam logic [31:0] CH_DEN      = 32'd2457600000;
    localparam logic [40:0] CH_HALF     = 41'd1228800000;
    localparam logic [40:0] CH_MAX      = 41'd255;

    localparam logic [63:0] CH_RECIP_W  = (64'd1 << 48) / {32'd0, CH_DEN};
    localparam logic [16:0] CH_RECIP    = CH_RECIP_W[16:0];

endpackage

/* rtl/hsla_front.sv */
module hsla_front import hsla_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_hsla_in  i_pix,
    output t_chan_num o_num
);

    // stage 1: clamps, hue wrap and split into sector count and offset
    logic [17:0] w_hext;
    logic [17:0] w_hbias;
    logic [16:0] w_u;
    logic [23:0] w_qprod;
    logic [6:0]  w_q;
    logic [16:0] w_off;
    logic [10:0] w_s;
    logic [10:0] w_l;

    logic [6:0]  r_q;
    logic [9:0]  r_off;
    logic [10:0] r_s;
    logic [10:0] r_l;

    assign w_hext  = {{2{i_pix.hue[15]}}, i_pix.hue};
    assign w_hbias = w_hext + HUE_BIAS;
    assign w_u     = w_hbias[16:0];
    assign w_qprod = 24'(w_u[16:6]) * 24'(HUE_RECIP15);
    assign w_q     = w_qprod[22:16];
    assign w_off   = w_u - 17'(w_q) * HUE_SECTOR;

    always_comb begin
        if (i_pix.saturation[11]) begin
            w_s = '0;
        end else if (i_pix.saturation[10:0] > PCT_FULL) begin
            w_s = PCT_FULL;
        end else begin
            w_s = i_pix.saturation[10:0];
        end
        if (i_pix.lightness[11]) begin
            w_l = '0;
        end else if (i_pix.lightness[10:0] > PCT_FULL) begin
            w_l = PCT_FULL;
        end else begin
            w_l = i_pix.lightness[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= w_q;
            r_off <= w_off[9:0];
            r_s   <= w_s;
            r_l   <= w_l;
        end
    end

    // stage 2: sector, triangle weight, chroma numerator
    logic [11:0] w_sprod;
    logic [6:0]  w_secw;
    logic [2:0]  w_sec;
    logic [9:0]  w_tri;
    logic [11:0] w_l2x;
    logic [10:0] w_twol;
    logic [10:0] w_cw;
    logic [21:0] w_cn;

    logic [2:0]  r_sec2;
    logic [9:0]  r_tri;
    logic [21:0] r_cn;
    logic [10:0] r_l2;

    assign w_sprod = 12'(r_q) * SEC_RECIP6;
    assign w_secw  = r_q - 7'(w_sprod[11:8]) * SEC_COUNT;
    assign w_sec   = w_secw[2:0];
    // odd sectors run down the triangle
    assign w_tri   = w_sec[0] ? (10'(HUE_SECTOR) - r_off) : r_off;
    assign w_l2x   = {r_l, 1'b0};
    assign w_twol  = (r_l >= PCT_HALF) ? 11'(w_l2x - 12'(PCT_FULL))
                                       : 11'(12'(PCT_FULL) - w_l2x);
    assign w_cw    = PCT_FULL - w_twol;
    assign w_cn    = 22'(w_cw) * 22'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec2 <= w_sec;
            r_tri  <= w_tri;
            r_cn   <= w_cn;
            r_l2   <= r_l;
        end
    end

    // stage 3: chroma, second component and offset over the common denominator
    logic [31:0] w_cd;
    logic [31:0] w_xd;
    logic [31:0] w_lterm;
    logic [31:0] w_cterm;

    logic [2:0]  r_sec3;
    logic [31:0] r_cd;
    logic [31:0] r_xd;
    logic [31:0] r_md;

    assign w_cd    = 32'(r_cn) * CD_SCALE;
    assign w_xd    = 32'(r_cn) * 32'(r_tri);
    assign w_lterm = 32'(r_l2) * MD_SCALE;
    assign w_cterm = 32'(r_cn) * CN_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec3 <= r_sec2;
            r_cd   <= w_cd;
            r_xd   <= w_xd;
            // offset never goes negative for clamped inputs
            r_md   <= w_lterm - w_cterm;
        end
    end

    // stage 4: sector mapping and offset add
    logic [31:0] w_r;
    logic [31:0] w_g;
    logic [31:0] w_b;
    t_chan_num   r_num;

    always_comb begin
        case (t_sector'(r_sec3))
            SEC_RED_YEL: begin
                w_r = r_cd; w_g = r_xd; w_b = '0;
            end
            SEC_YEL_GRN: begin
                w_r = r_xd; w_g = r_cd; w_b = '0;
            end
            SEC_GRN_CYN: begin
                w_r = '0;   w_g = r_cd; w_b = r_xd;
            end
            SEC_CYN_BLU: begin
                w_r = '0;   w_g = r_xd; w_b = r_cd;
            end
            SEC_BLU_MAG: begin
                w_r = r_xd; w_g = '0;   w_b = r_cd;
            end
            default: begin
                w_r = r_cd; w_g = '0;   w_b = r_xd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num.red   <= {1'b0, w_r} + {1'b0, r_md};
            r_num.green <= {1'b0, w_g} + {1'b0, r_md};
            r_num.blue  <= {1'b0, w_b} + {1'b0, r_md};
        end
    end

    assign o_num = r_num;

endmodule

/* rtl/hsla_scale.sv */
module hsla_scale import hsla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_num,
    output logic [7:0]  o_chan
);

    // stage 5: scale by 255 and add half for round to nearest
    logic [40:0] r_n;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= 41'(i_num) * CH_MAX + CH_HALF;
        end
    end

    // stage 6: reciprocal estimate, low by at most one
    logic [33:0] w_qe_prod;
    logic [9:0]  r_qe;
    logic [40:0] r_n2;

    assign w_qe_prod = 34'(r_n[40:24]) * 34'(CH_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qe <= w_qe_prod[33:24];
            r_n2 <= r_n;
        end
    end

    // stage 7: remainder check, correct and saturate
    logic [41:0] w_rem;
    logic [10:0] w_q;
    logic [7:0]  r_chan;

    assign w_rem = {1'b0, r_n2} - 42'(r_qe) * 42'(CH_DEN);
    assign w_q   = {1'b0, r_qe} + ((w_rem >= 42'(CH_DEN)) ? 11'd1 : 11'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= (w_q > 11'(CH_MAX)) ? 8'(CH_MAX) : w_q[7:0];
        end
    end

    assign o_chan = r_chan;

endmodule

/* rtl/hsla_to_rgba_converter_unit.sv */
// hsla to rgba color converter, fixed point, exact rounding
// the result is registered through the front and scaler stages after input accept
// throughput: one item per cycle; the whole pipeline advances together and
// holds only while a result is waiting and the output side stalls
// reset (i_rst_n low, synchronous) clears the valid bits, data regs keep garbage
module hsla_to_rgba_converter_unit import hsla_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_valid,
    input  t_hsla_in  i_hsla,
    output logic      o_stall,
    // output channel
    output logic      o_valid,
    output t_rgba_out o_rgba,
    input  logic      i_stall
);

    // pipeline advance: free unless a finished item is held by the sink
    logic w_en;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign w_en    = ~(r_vld[PIPE_DEPTH-1] & i_stall);
    assign o_stall = ~w_en;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // alpha only needs a clamp, then rides a delay line to line up with rgb
    logic [7:0] w_alpha;
    logic [7:0] r_alpha [PIPE_DEPTH];

    assign w_alpha = (i_hsla.opacity > 10'(CH_MAX)) ? 8'(CH_MAX) : i_hsla.opacity[7:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alpha[0] <= w_alpha;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // stages 1-4: clamps, hue sector, chroma and per-channel numerators
    t_chan_num w_num;

    hsla_front u_front (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_pix (i_hsla),
        .o_num (w_num)
    );

    // stages 5-7: scale to 0..255 with round to nearest, one scaler per channel
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    hsla_scale u_scale_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num.red),
        .o_chan (w_red)
    );

    hsla_scale u_scale_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num.green),
        .o_chan (w_green)
    );

    hsla_scale u_scale_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num.blue),
        .o_chan (w_blue)
    );

    // last stage regs of the scalers form the output register
    assign o_rgba.red       = w_red;
    assign o_rgba.green     = w_green;
    assign o_rgba.blue      = w_blue;
    assign o_rgba.alpha_out = r_alpha[PIPE_DEPTH-1];

endmodule
